// ===== design/qps_pkg.sv =====
// ----------------------------------------------------------------------------
// qps_pkg
// Shared constants, codes and control structs for the queue proportional
// sampler.
// ----------------------------------------------------------------------------
package qps_pkg;

  localparam int NUM_QUEUES  = 64;
  localparam int LENGTH_BITS = 16;

  // fixed field widths of the channels
  localparam int IDX_W  = 6;
  localparam int QLEN_W = 16;
  localparam int RND_W  = 32;
  localparam int PORT_W = 6;

  localparam int ADDR_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int TOTAL_W = LENGTH_BITS + $clog2(NUM_QUEUES);
  localparam int CNT_W   = $clog2(RND_W);

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SET_RD = 3'd1;
  localparam logic [2:0] ST_SET_WR = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  typedef struct packed {
    logic capture;
    logic set_wr;
    logic div_step;
    logic walk_init;
    logic walk_step;
    logic res_load;
    logic res_found;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic div_last;
    logic hit;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/qps_if.sv =====
// ----------------------------------------------------------------------------
// qps channel interfaces
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface qps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [qps_pkg::IDX_W-1:0]   queue_index;
  logic [qps_pkg::QLEN_W-1:0]  queue_length;
  logic [qps_pkg::RND_W-1:0]   random_value;

  modport source (output valid, op, queue_index, queue_length, random_value,
                  input ready);
  modport sink   (input valid, op, queue_index, queue_length, random_value,
                  output ready);
endinterface

interface qps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        port_valid;
  logic [qps_pkg::PORT_W-1:0]  chosen_port;

  modport source (output valid, port_valid, chosen_port, input ready);
  modport sink   (input valid, port_valid, chosen_port, output ready);
endinterface

// ===== design/qps_ctrl.sv =====
// ----------------------------------------------------------------------------
// qps_ctrl
// Controller: sequences set updates, the bit-serial modulo and the walk
// over the queue lengths, and hands results to the output register.
// ----------------------------------------------------------------------------
module qps_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_op,
  input  logic [qps_pkg::IDX_W-1:0]  in_queue_index,
  input  qps_pkg::dp_status_t        status,
  output logic                       in_ready,
  output qps_pkg::ctrl_cmd_t         cmd
);

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       idx_ok;

  assign idx_ok   = int'(in_queue_index) < qps_pkg::NUM_QUEUES;
  assign in_ready = (state_r == qps_pkg::ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      qps_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op == qps_pkg::OP_SAMPLE) begin
            if (status.total_zero) begin
              cmd.res_load  = 1'b1;
              cmd.res_found = 1'b0;
              state_nxt     = qps_pkg::ST_DONE;
            end else begin
              state_nxt = qps_pkg::ST_DIV;
            end
          end else if (idx_ok) begin
            state_nxt = qps_pkg::ST_SET_RD;
          end
        end
      end
      qps_pkg::ST_SET_RD: begin
        state_nxt = qps_pkg::ST_SET_WR;
      end
      qps_pkg::ST_SET_WR: begin
        cmd.set_wr = 1'b1;
        state_nxt  = qps_pkg::ST_IDLE;
      end
      qps_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.walk_init = 1'b1;
          state_nxt     = qps_pkg::ST_WALK;
        end
      end
      qps_pkg::ST_WALK: begin
        if (status.hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = qps_pkg::ST_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      qps_pkg::ST_DONE: begin
        // hold until the output register can take the word
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = qps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/qps_dp.sv =====
// ----------------------------------------------------------------------------
// qps_dp
// Datapath: length memory with valid bits, running total, restoring
// modulo unit, cumulative walk and output register.
// ----------------------------------------------------------------------------
module qps_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [qps_pkg::IDX_W-1:0]   in_queue_index,
  input  logic [qps_pkg::QLEN_W-1:0]  in_queue_length,
  input  logic [qps_pkg::RND_W-1:0]   in_random_value,
  input  qps_pkg::ctrl_cmd_t          cmd,
  input  logic                        out_ready,
  output qps_pkg::dp_status_t         status,
  output logic                        out_valid,
  output logic                        out_port_valid,
  output logic [qps_pkg::PORT_W-1:0]  out_chosen_port
);

  localparam int AW = qps_pkg::ADDR_W;
  localparam int LW = qps_pkg::LENGTH_BITS;
  localparam int TW = qps_pkg::TOTAL_W;
  localparam int RW = qps_pkg::RND_W;
  localparam int CW = qps_pkg::CNT_W;

  logic [LW-1:0]  len_mem [qps_pkg::NUM_QUEUES];
  logic [qps_pkg::NUM_QUEUES-1:0] len_vld_r;
  logic [LW-1:0]  rd_data_r;
  logic           rd_vld_r;
  logic [AW-1:0]  rd_addr;
  logic [LW-1:0]  eff_len;

  logic [AW-1:0]  idx_r;
  logic [LW-1:0]  len_r;
  logic [TW-1:0]  total_r;

  logic [TW-1:0]  rem_r;
  logic [TW-1:0]  rem_nxt;
  logic [RW-1:0]  rnd_sh_r;
  logic [CW-1:0]  cnt_r;
  logic [TW:0]    trial;
  logic [TW:0]    trial_sub;

  logic [AW-1:0]  addr_r;
  logic [AW-1:0]  chk_idx_r;
  logic           pend_r;
  logic [TW-1:0]  cum_r;
  logic [TW-1:0]  cum_sum;

  logic                       res_found_r;
  logic [qps_pkg::PORT_W-1:0] res_port_r;
  logic                       out_valid_r;
  logic                       out_pv_r;
  logic [qps_pkg::PORT_W-1:0] out_port_r;

  assign rd_addr = cmd.walk_step ? addr_r : idx_r;
  assign eff_len = rd_vld_r ? rd_data_r : '0;

  // length memory, registered read
  always_ff @(posedge clk) begin
    rd_data_r <= len_mem[rd_addr];
    if (cmd.set_wr) begin
      len_mem[idx_r] <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      total_r   <= '0;
    end else begin
      rd_vld_r <= len_vld_r[rd_addr];
      if (cmd.set_wr) begin
        len_vld_r[idx_r] <= 1'b1;
        total_r          <= total_r - TW'(eff_len) + TW'(len_r);
      end
    end
  end

  // restoring modulo, one quotient bit per cycle
  assign trial     = {rem_r, rnd_sh_r[RW-1]};
  assign trial_sub = trial - {1'b0, total_r};
  assign rem_nxt   = (trial >= {1'b0, total_r}) ? TW'(trial_sub) : TW'(trial);

  assign cum_sum = cum_r + TW'(eff_len);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r    <= AW'(in_queue_index);
      len_r    <= LW'(in_queue_length);
      rnd_sh_r <= in_random_value;
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      rnd_sh_r <= {rnd_sh_r[RW-2:0], 1'b0};
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_r + CW'(1);
    end
    if (cmd.walk_init) begin
      addr_r <= '0;
      cum_r  <= '0;
    end else if (cmd.walk_step) begin
      addr_r    <= addr_r + AW'(1);
      chk_idx_r <= addr_r;
      if (pend_r) begin
        cum_r <= cum_sum;
      end
    end
    if (cmd.res_load) begin
      res_found_r <= cmd.res_found;
      res_port_r  <= cmd.res_found ? qps_pkg::PORT_W'(chk_idx_r) : '0;
    end
    if (cmd.out_load) begin
      out_pv_r   <= res_found_r;
      out_port_r <= res_port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.walk_init) begin
        pend_r <= 1'b0;
      end else if (cmd.walk_step) begin
        pend_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.total_zero = (total_r == '0);
  assign status.div_last   = (cnt_r == CW'(RW - 1));
  assign status.hit        = pend_r && (rem_r < cum_sum);
  assign status.out_busy   = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_port_valid  = out_pv_r;
  assign out_chosen_port = out_port_r;

endmodule

// ===== design/queue_proportional_sampler.sv =====
// Set word: read old length, then write length and total; result-free.
// Sample word: accept, bit-serial modulo, a walk from queue 0 to the chosen
//   queue (one memory read per cycle), then a load of the output register
//   once it is free; empty sample: accept, load. One word in flight at a time.
// Reset clears the per-queue valid bits and the total, so all lengths read as
//   zero at once; no clearing pass.
// ----------------------------------------------------------------------------
// queue_proportional_sampler
// Picks an output port with probability proportional to its queue length by
// inverse CDF over the stored lengths.
// ----------------------------------------------------------------------------
module queue_proportional_sampler (
  input  logic        clk,
  input  logic        rst_n,
  qps_in_if.sink      in_if,
  qps_out_if.source   out_if
);

  qps_pkg::ctrl_cmd_t cmd;
  qps_pkg::dp_status_t status;

  qps_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_op          (in_if.op),
    .in_queue_index (in_if.queue_index),
    .status         (status),
    .in_ready       (in_if.ready),
    .cmd            (cmd)
  );

  qps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_queue_index  (in_if.queue_index),
    .in_queue_length (in_if.queue_length),
    .in_random_value (in_if.random_value),
    .cmd             (cmd),
    .out_ready       (out_if.ready),
    .status          (status),
    .out_valid       (out_if.valid),
    .out_port_valid  (out_if.port_valid),
    .out_chosen_port (out_if.chosen_port)
  );

endmodule

// ===== design/qps_checker.sv =====
// ----------------------------------------------------------------------------
// qps_checker
// Port-level checks for the queue proportional sampler, bound to the top.
// ----------------------------------------------------------------------------
module qps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_port_valid,
  input logic [qps_pkg::PORT_W-1:0] out_chosen_port
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_port_valid)
      && $stable(out_chosen_port))
    else $error("result word changed while stalled");

  a_empty_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_port_valid |-> out_chosen_port == '0)
    else $error("empty result carries a nonzero port");

  a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_op == qps_pkg::OP_SET |=> !$rose(out_valid))
    else $error("set word produced a result");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_op == qps_pkg::OP_SAMPLE |=> !in_ready)
    else $error("input taken again right after a sample word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind queue_proportional_sampler qps_checker u_qps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_op           (in_if.op),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_port_valid  (out_if.port_valid),
  .out_chosen_port (out_if.chosen_port)
);

// ===== tb/qps_sample_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qps_sample_checker
// Watches the input and result channels of the queue proportional sampler,
// keeps a shadow copy of the queue lengths and their total, predicts the port
// picked by each sample word and compares every result word in order.
// ----------------------------------------------------------------------------
module qps_sample_checker
  import qps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  qps_in_if    in_mon,
  qps_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   set_count,
  output int   sample_count,
  output int   empty_count
);

  typedef struct packed {
    logic              port_valid;
    logic [PORT_W-1:0] chosen_port;
  } pick_t;

  logic [LENGTH_BITS-1:0] shadow_len [NUM_QUEUES];
  logic [TOTAL_W-1:0]     shadow_total;
  pick_t                  expected_picks [$];
  pick_t                  want;
  pick_t                  pick;

  // inverse CDF over the shadow lengths
  function automatic pick_t predict_pick(input logic [RND_W-1:0] rnd);
    pick_t            p;
    logic [RND_W-1:0] target;
    logic [TOTAL_W:0] cum;
    logic             found;
    p     = '0;
    cum   = '0;
    found = 1'b0;
    if (shadow_total != '0) begin
      target       = rnd % RND_W'(shadow_total);
      p.port_valid = 1'b1;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        cum = cum + shadow_len[q];
        if (!found && target < cum) begin
          found         = 1'b1;
          p.chosen_port = PORT_W'(q);
        end
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) shadow_len[q] = '0;
      shadow_total = '0;
      expected_picks.delete();
      fail_count   = 0;
      set_count    = 0;
      sample_count = 0;
      empty_count  = 0;
    end else begin
      // check results before queuing a new word so a stray result never
      // pairs with the word accepted on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_picks.size() == 0) begin
          $error("result word with nothing expected: port_valid %0d chosen_port %0d",
                 out_mon.port_valid, out_mon.chosen_port);
          fail_count++;
        end else begin
          want = expected_picks.pop_front();
          if (out_mon.port_valid !== want.port_valid) begin
            $error("port_valid: expected %0d, actual %0d",
                   want.port_valid, out_mon.port_valid);
            fail_count++;
          end
          if (out_mon.chosen_port !== want.chosen_port) begin
            $error("chosen_port: expected %0d, actual %0d",
                   want.chosen_port, out_mon.chosen_port);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_SET) begin
          if (int'(in_mon.queue_index) < NUM_QUEUES) begin
            shadow_total = shadow_total - shadow_len[in_mon.queue_index]
                           + in_mon.queue_length[LENGTH_BITS-1:0];
            shadow_len[in_mon.queue_index] = in_mon.queue_length[LENGTH_BITS-1:0];
          end
          set_count++;
        end else begin
          pick = predict_pick(in_mon.random_value);
          expected_picks.push_back(pick);
          sample_count++;
          if (!pick.port_valid) empty_count++;
        end
      end
    end
    pending = expected_picks.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the queue proportional sampler: directed corner
// words, then random set and sample traffic over four idle/stall phases with
// one long receiver hold-off. Checking is done by qps_sample_checker.
// ----------------------------------------------------------------------------
module tb;
  import qps_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int RESET_CYCLES    = 7;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   set_count;
  int   sample_count;
  int   empty_count;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  bit   hold_armed     = 1'b0;
  bit   hold_done      = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;

  qps_in_if  in_ch ();
  qps_out_if out_ch ();

  queue_proportional_sampler u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  qps_sample_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .set_count    (set_count),
    .sample_count (sample_count),
    .empty_count  (empty_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial out_ch.ready = 1'b0;

  // receiver: random stalls, plus one long hold-off once armed
  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // offer one word and hold it until accepted
  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [QLEN_W-1:0] qlen,
                           input logic [RND_W-1:0] rnd);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.queue_index  <= idx;
    in_ch.queue_length <= qlen;
    in_ch.random_value <= rnd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // unused fields carry random bits
  task automatic set_len(input logic [IDX_W-1:0] idx, input logic [QLEN_W-1:0] qlen);
    send_word(OP_SET, idx, qlen, $urandom);
  endtask

  task automatic sample(input logic [RND_W-1:0] rnd);
    send_word(OP_SAMPLE, IDX_W'($urandom), QLEN_W'($urandom), rnd);
  endtask

  task automatic send_random_word(input int zero_pct);
    int               r;
    int               m;
    logic [QLEN_W-1:0] qlen;
    logic [RND_W-1:0]  rnd;
    r = $urandom_range(99);
    if (r < 45) begin
      m = $urandom_range(99);
      if (m < 60)      rnd = $urandom;
      else if (m < 80) rnd = RND_W'($urandom_range(255));
      else             rnd = ~RND_W'($urandom_range(255));
      sample(rnd);
    end else begin
      m = $urandom_range(99);
      if (m < zero_pct)           qlen = '0;
      else if (m < zero_pct + 15) qlen = '1;
      else if (m < zero_pct + 35) qlen = QLEN_W'($urandom_range(1, 15));
      else                        qlen = QLEN_W'($urandom);
      set_len(IDX_W'($urandom), qlen);
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct,
                           input int count, input int zero_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_random_word(zero_pct);
  endtask

  task automatic fill_all(input logic [QLEN_W-1:0] qlen);
    for (int q = 0; q < NUM_QUEUES; q++) set_len(IDX_W'(q), qlen);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SET;
    in_ch.queue_index  = '0;
    in_ch.queue_length = '0;
    in_ch.random_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // all queues empty
    sample('0);
    sample('1);
    // single queue at the far end: walk over every empty queue
    set_len(IDX_W'(NUM_QUEUES - 1), '1);
    sample('0);
    sample('1);
    // one word in queue 0, then wrap of the random word
    set_len('0, QLEN_W'(1));
    sample('0);
    sample(RND_W'(1));
    sample(RND_W'(32'h0001_0000));
    // overwrite queue 0, probe the cumulative boundary
    set_len('0, '1);
    sample(RND_W'(32'h0000_FFFF));
    sample(RND_W'(32'h0000_FFFE));
    // alternating bit patterns in index and length
    set_len(IDX_W'(6'h2A), QLEN_W'(16'hAAAA));
    set_len(IDX_W'(6'h15), QLEN_W'(16'h5555));
    sample(RND_W'(32'hAAAA_AAAA));
    sample(RND_W'(32'h5555_5555));
    // drop the ends, last target lands on the last nonzero queue
    set_len(IDX_W'(NUM_QUEUES - 1), '0);
    set_len('0, '0);
    sample('1);
    sample(RND_W'(32'h0000_FFFE));
    // back to empty
    set_len(IDX_W'(6'h15), '0);
    set_len(IDX_W'(6'h2A), '0);
    sample(RND_W'($urandom));

    // no idling, long receiver hold-off fills the block
    hold_armed = 1'b1;
    run_phase(0, 0, 170, 15);

    // sender idles; start from the largest possible total
    src_idle_pct = 65;
    fill_all('1);
    run_phase(65, 0, 120, 10);

    run_phase(0, 65, 170, 15);

    // both idle; clear everything and keep the queues sparse
    src_idle_pct   = 30;
    sink_stall_pct = 30;
    fill_all('0);
    run_phase(30, 30, 100, 70);

    in_ch.valid <= 1'b0;
    // let the checker count the last accepted word before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d set words and %0d samples (%0d with every queue empty)",
             set_count, sample_count, empty_count);
    $display("across four idle/stall phases, a full and a sparse length table");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/qps_pkg.sv
design/qps_if.sv
design/qps_ctrl.sv
design/qps_dp.sv
design/queue_proportional_sampler.sv
design/qps_checker.sv
tb/qps_sample_checker.sv
tb/tb.sv
